>>> hdl/hmmfwd_pkg.sv
`timescale 1ns / 1ps
package hmmfwd_pkg;

    typedef enum logic [1:0] {
        ACT_WR_TRANS = 2'd0,
        ACT_WR_EMIS  = 2'd1,
        ACT_WR_INIT  = 2'd2,
        ACT_OBSERVE  = 2'd3
    } action_t;

    localparam int unsigned STATE_W = 2;
    localparam int unsigned COL_W   = 5;
    localparam int unsigned PROB_W  = 17;
    localparam int unsigned SYM_W   = 5;
    localparam int unsigned SCALE_W = 32;
    localparam int unsigned CFG_W   = 3;

    localparam int MAX_STATES = 4;
    localparam int SYMBOLS    = 27;
    localparam int FRAC_BITS  = 16;

    // divider handshake between sequencer and divider
    typedef struct packed {
        logic start;
    } div_req_t;

    typedef struct packed {
        logic done;
    } div_rsp_t;

endpackage

>>> hdl/hmmfwd_ram.sv
`timescale 1ns / 1ps
module hmmfwd_ram #(
    parameter int WIDTH = 17,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

>>> hdl/hmmfwd_div.sv
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle: quot = num / den.
module hmmfwd_div #(
    parameter int NUM_W = 48,
    parameter int DEN_W = 20
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  hmmfwd_pkg::div_req_t  req,
    input  logic [NUM_W-1:0]      num,
    input  logic [DEN_W-1:0]      den,
    output hmmfwd_pkg::div_rsp_t  rsp,
    output logic [NUM_W-1:0]      quot
);
    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] quot_reg;
    logic [DEN_W:0]   rem_reg;
    logic [DEN_W-1:0] den_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [DEN_W:0]   trial;

    assign trial = {rem_reg[DEN_W-1:0], quot_reg[NUM_W-1]};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(NUM_W);
                quot_reg <= num;
                rem_reg  <= '0;
                den_reg  <= den;
            end else if (busy_reg) begin
                if (trial >= {1'b0, den_reg}) begin
                    rem_reg  <= trial - {1'b0, den_reg};
                    quot_reg <= {quot_reg[NUM_W-2:0], 1'b1};
                end else begin
                    rem_reg  <= trial;
                    quot_reg <= {quot_reg[NUM_W-2:0], 1'b0};
                end
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign rsp.done = done_reg;
    assign quot     = quot_reg;
endmodule

>>> hdl/hmm_scaled_forward_pass.sv
`timescale 1ns / 1ps
// Channel | Dir | Beat fields
// s_axis  | in  | tdata: action, row, col, value, symbol, seq_start
// m_axis  | out | tdata: state_index, scaled_alpha, scale_factor, zero_sum; tlast
// cfg     | in  | cfg_wen / cfg_wdata: states_in_use
// A table write passes through S_WRITE. An observation with history runs the prediction
// over the previous alphas; a sequence start takes the initial probabilities instead, and
// a zero sum does not wait for the divider. The work is serialised by the single shared
// multiplier, the bit-serial reciprocal divider and the one read port of each table, and
// an m_tready stall holds it.
// Reset (aresetn low, synchronous) clears previous alphas and the sequence flag.
// s_tready is low while an item is worked on; a stalled m_tready holds the beat.
module hmm_scaled_forward_pass (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wen,
    input  logic [2:0]  cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // action[1:0] row[3:2] col[8:4] value[25:9] symbol[30:26] seq_start[31]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // state_index[1:0] scaled_alpha[18:2] scale_factor[50:19] zero_sum[51]
    output logic        m_tlast
);
    localparam int MAX_STATES = hmmfwd_pkg::MAX_STATES;
    localparam int SYMBOLS    = hmmfwd_pkg::SYMBOLS;
    localparam int FRAC_BITS  = hmmfwd_pkg::FRAC_BITS;
    localparam int SI_W   = (MAX_STATES > 1) ? $clog2(MAX_STATES) : 1;
    localparam int TR_D   = MAX_STATES * MAX_STATES;
    localparam int TR_AW  = $clog2(TR_D) > 0 ? $clog2(TR_D) : 1;
    localparam int EM_D   = MAX_STATES * SYMBOLS;
    localparam int EM_AW  = $clog2(EM_D);
    localparam int PW     = FRAC_BITS + 1;
    localparam int ACC_W  = 2 * PW + SI_W + 1;
    localparam int SUM_W  = PW + SI_W + 1;
    localparam int NUM_W  = 2 * FRAC_BITS + 1;
    localparam int CNT_W  = SI_W + 1;
    localparam logic [PW-1:0] ONE = PW'(1) << FRAC_BITS;

    typedef enum logic [3:0] {
        S_IDLE, S_WRITE, S_PRED_RD, S_PRED_MAC, S_PRED_WAIT_FIX, S_PRED_END, S_EM_RD,
        S_EM_MUL, S_DIV_GO, S_DIV_WAIT, S_NORM_PRE, S_NORM, S_OUT_LD, S_OUT
    } state_t;

    state_t state_reg;

    // input fields
    logic [1:0]  in_action;
    logic [1:0]  in_row;
    logic [4:0]  in_col;
    logic [16:0] in_value;
    logic [4:0]  in_symbol;
    logic        in_start;
    assign in_action = s_tdata[1:0];
    assign in_row    = s_tdata[3:2];
    assign in_col    = s_tdata[8:4];
    assign in_value  = s_tdata[25:9];
    assign in_symbol = s_tdata[30:26];
    assign in_start  = s_tdata[31];

    logic [2:0] cfg_reg;
    logic [CNT_W-1:0] n_act;
    always_comb begin
        if (cfg_reg == 3'd0) n_act = CNT_W'(1);
        else if (32'(cfg_reg) > MAX_STATES) n_act = CNT_W'(MAX_STATES);
        else n_act = CNT_W'(cfg_reg);
    end

    // latched item
    logic [1:0]  act_reg;
    logic [1:0]  row_reg;
    logic [4:0]  col_reg;
    logic [PW-1:0] val_reg;
    logic [4:0]  sym_reg;
    logic        use_init_reg;
    logic        have_prev_reg;

    // tables
    logic             tr_we, em_we;
    logic [TR_AW-1:0] tr_waddr, tr_raddr;
    logic [EM_AW-1:0] em_waddr, em_raddr;
    logic [PW-1:0]    tr_rdata, em_rdata;
    logic [PW-1:0]    init_reg [MAX_STATES];
    logic [PW-1:0]    prev_reg [MAX_STATES];
    logic [SUM_W-1:0] raw_reg  [MAX_STATES];

    hmmfwd_ram #(.WIDTH(PW), .DEPTH(TR_D)) u_tr (
        .aclk(aclk), .we(tr_we), .waddr(tr_waddr), .wdata(val_reg),
        .raddr(tr_raddr), .rdata(tr_rdata));
    hmmfwd_ram #(.WIDTH(PW), .DEPTH(EM_D)) u_em (
        .aclk(aclk), .we(em_we), .waddr(em_waddr), .wdata(val_reg),
        .raddr(em_raddr), .rdata(em_rdata));

    logic [SI_W-1:0] i_reg, j_reg;
    logic [ACC_W-1:0] acc_reg;
    logic [SUM_W-1:0] sum_reg;
    logic [PW-1:0]    pred_reg;
    logic [31:0]      scale_reg;
    logic             zero_reg;
    logic [PW-1:0]    alpha_reg;
    logic             sym_ok;

    assign sym_ok = 32'(sym_reg) < SYMBOLS;

    // write address decode
    assign tr_we    = (state_reg == S_WRITE) && (act_reg == hmmfwd_pkg::ACT_WR_TRANS)
                      && (32'(row_reg) < MAX_STATES) && (32'(col_reg) < MAX_STATES);
    assign em_we    = (state_reg == S_WRITE) && (act_reg == hmmfwd_pkg::ACT_WR_EMIS)
                      && (32'(row_reg) < MAX_STATES) && (32'(col_reg) < SYMBOLS);
    assign tr_waddr = TR_AW'(32'(row_reg) * MAX_STATES + 32'(col_reg));
    assign em_waddr = EM_AW'(32'(row_reg) * SYMBOLS + 32'(col_reg));
    assign tr_raddr = TR_AW'(32'(j_reg) * MAX_STATES + 32'(i_reg));
    assign em_raddr = EM_AW'(32'(i_reg) * SYMBOLS + 32'(sym_reg));

    // shared multiplier: operands picked per state
    logic [SUM_W-1:0] mul_a;
    logic [31:0]      mul_b;
    logic [SUM_W+31:0] mul_p;
    always_comb begin
        case (state_reg)
            S_PRED_MAC: begin
                mul_a = SUM_W'(prev_reg[j_reg]);
                mul_b = 32'(tr_rdata);
            end
            S_EM_MUL: begin
                mul_a = SUM_W'(pred_reg);
                mul_b = sym_ok ? 32'(em_rdata) : 32'd0;
            end
            S_NORM: begin
                mul_a = raw_reg[i_reg];
                mul_b = scale_reg;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        mul_p = (SUM_W + 32)'(mul_a) * (SUM_W + 32)'(mul_b);
    end

    // divider
    hmmfwd_pkg::div_req_t div_req;
    hmmfwd_pkg::div_rsp_t div_rsp;
    logic [NUM_W-1:0] div_q;
    assign div_req.start = (state_reg == S_DIV_GO);

    hmmfwd_div #(.NUM_W(NUM_W), .DEN_W(SUM_W)) u_div (
        .aclk(aclk), .aresetn(aresetn), .req(div_req),
        .num(NUM_W'(1) << (2 * FRAC_BITS)), .den(sum_reg),
        .rsp(div_rsp), .quot(div_q));

    logic [SUM_W+31-FRAC_BITS:0] norm_sh;
    assign norm_sh = mul_p[SUM_W+31:FRAC_BITS];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            have_prev_reg <= 1'b0;
            m_tvalid      <= 1'b0;
            cfg_reg       <= 3'd2;
            for (int k = 0; k < MAX_STATES; k++) prev_reg[k] <= '0;
        end else begin
            if (cfg_wen) begin
                cfg_reg <= cfg_wdata;
            end
            case (state_reg)
                S_IDLE: begin
                    if (s_tvalid) begin
                        act_reg <= in_action;
                        row_reg <= in_row;
                        col_reg <= in_col;
                        val_reg <= (in_value > 17'(ONE)) ? ONE : PW'(in_value);
                        sym_reg <= in_symbol;
                        use_init_reg <= in_start || !have_prev_reg;
                        i_reg   <= '0;
                        j_reg   <= '0;
                        sum_reg <= '0;
                        state_reg <= (in_action == hmmfwd_pkg::ACT_OBSERVE) ? S_PRED_RD
                                                                             : S_WRITE;
                    end
                end
                S_WRITE: begin
                    if (act_reg == hmmfwd_pkg::ACT_WR_INIT && 32'(col_reg) < MAX_STATES) begin
                        init_reg[col_reg[SI_W-1:0]] <= val_reg;
                    end
                    state_reg <= S_IDLE;
                end
                S_PRED_RD: begin
                    // table read address is j_reg/i_reg; data next cycle
                    acc_reg <= '0;
                    j_reg   <= '0;
                    if (use_init_reg) begin
                        pred_reg  <= init_reg[i_reg];
                        state_reg <= S_EM_RD;
                    end else begin
                        state_reg <= S_PRED_MAC;
                    end
                end
                S_PRED_MAC: begin
                    acc_reg <= acc_reg + ACC_W'(mul_p);
                    if (CNT_W'(j_reg) == n_act - 1'b1) begin
                        state_reg <= S_PRED_END;
                    end else begin
                        j_reg     <= j_reg + 1'b1;
                        state_reg <= S_PRED_WAIT_FIX;
                    end
                end
                S_PRED_END: begin
                    pred_reg  <= PW'(acc_reg >> FRAC_BITS);
                    state_reg <= S_EM_RD;
                end
                S_EM_RD: state_reg <= S_EM_MUL;
                S_EM_MUL: begin
                    raw_reg[i_reg] <= SUM_W'(mul_p >> FRAC_BITS);
                    sum_reg <= sum_reg + SUM_W'(mul_p >> FRAC_BITS);
                    if (CNT_W'(i_reg) == n_act - 1'b1) begin
                        state_reg <= S_DIV_GO;
                    end else begin
                        // restart the transition column at row zero
                        i_reg     <= i_reg + 1'b1;
                        j_reg     <= '0;
                        state_reg <= S_PRED_RD;
                    end
                end
                S_DIV_GO: begin
                    zero_reg  <= (sum_reg == '0);
                    state_reg <= (sum_reg == '0) ? S_NORM_PRE : S_DIV_WAIT;
                end
                S_DIV_WAIT: begin
                    if (div_rsp.done) begin
                        scale_reg <= (div_q > NUM_W'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF
                                                                     : 32'(div_q);
                        i_reg     <= '0;
                        state_reg <= S_NORM;
                    end
                end
                S_NORM_PRE: begin
                    scale_reg <= 32'hFFFF_FFFF;
                    i_reg     <= '0;
                    state_reg <= S_NORM;
                end
                S_NORM: begin
                    if (zero_reg) alpha_reg <= '0;
                    else if (norm_sh > ($bits(norm_sh))'(ONE)) alpha_reg <= ONE;
                    else alpha_reg <= PW'(norm_sh);
                    state_reg <= S_OUT_LD;
                end
                S_OUT_LD: begin
                    prev_reg[i_reg] <= alpha_reg;
                    m_tdata  <= 56'({zero_reg, scale_reg, alpha_reg, 2'(i_reg)});
                    m_tlast  <= (CNT_W'(i_reg) == n_act - 1'b1);
                    m_tvalid <= 1'b1;
                    state_reg <= S_OUT;
                end
                S_OUT: begin
                    if (m_tready) begin
                        m_tvalid <= 1'b0;
                        if (m_tlast) begin
                            for (int k = 0; k < MAX_STATES; k++)
                                if (k >= 32'(n_act)) prev_reg[k] <= '0;
                            have_prev_reg <= 1'b1;
                            state_reg     <= S_IDLE;
                        end else begin
                            i_reg     <= i_reg + 1'b1;
                            state_reg <= S_NORM;
                        end
                    end
                end
                S_PRED_WAIT_FIX: state_reg <= S_PRED_MAC;
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign s_tready = (state_reg == S_IDLE);
endmodule
